/* hdl/blob_track_lifecycle_defines.svh */
// Assertion helpers shared by the track lifecycle modules.
`ifndef BLOB_TRACK_LIFECYCLE_DEFINES_SVH
`define BLOB_TRACK_LIFECYCLE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BTL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hdl/btl_pkg.sv */
package btl_pkg;

  localparam int unsigned TrailDepth = 20;
  localparam int unsigned TrailIdxW  = (TrailDepth > 1) ? $clog2(TrailDepth) : 1;
  localparam int unsigned TrailCntW  = $clog2(TrailDepth + 1);
  localparam int unsigned CfgAddrW   = 3;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_SEEN   = 3'd1,
    OP_MISSED = 3'd2,
    OP_TERM   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LS_NASCENT = 2'd0,
    LS_BORN    = 2'd1,
    LS_ALIVE   = 2'd2,
    LS_DEAD    = 2'd3
  } life_e;

  typedef enum logic [0:0] {
    REG_NASCENT_TIME = 1'b0,
    REG_DYING_TIME   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RD_REQ,
    CS_RD_EMIT
  } ctrl_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] time_ms;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
  } in_t;

  typedef struct packed {
    logic [1:0]  life_state;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        dying;
    logic [4:0]  trail_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] nascent_time_ms;
    logic [15:0] dying_time_ms;
  } cfg_t;

  typedef struct packed {
    logic load;        // latch accepted beat
    logic exec;        // apply event, emit status beat
    logic rd_start;    // set up trail walk
    logic rd_req;      // issue trail RAM read
    logic emit_point;  // emit one trail point
  } cmd_t;

  typedef struct packed {
    logic read_nonempty;
    logic out_free;
    logic rd_last;
  } status_t;

  // Box center in 12.4: left*16 + width*8, saturated to 16 bits.
  function automatic logic [15:0] box_center(logic [11:0] lo, logic [11:0] sz);
    logic [16:0] sum;
    sum = {1'b0, lo, 4'b0} + {2'b0, sz, 3'b0};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage

/* hdl/blob_track_lifecycle.sv */
// Track lifecycle engine for one touch blob. Each input beat is an event
// (start, seen, missed, terminate, read trail) with a millisecond stamp and a
// bounding box; each event yields one status beat carrying the life state,
// the 12.4 smoothed center, the dying mark and the trail fill, except a read
// of a non-empty trail, which yields one beat per held point, oldest first,
// with last set on the final one. An event is accepted, then executed; a
// trail read of up to 20 points is accepted and set up, then each point is
// read from the single registered read port of the trail RAM and emitted. An
// output stall holds the execute and emit steps. Results sit in an output
// register, so a new event is taken while the last beat still waits
// downstream. The trail RAM needs no clear after reset; only held points are
// ever read. Registers: 0x0 nascent time (ms), 0x4 dying time (ms), both 16
// bits, reset 500; write them only while the block is idle.
module blob_track_lifecycle import btl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  // event channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,

  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,

  // APB-style register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg_q, cfg_d;
  cmd_t    cmd;
  status_t st;
  logic    cfg_wr;

  // register block: index is the word address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_NASCENT_TIME: cfg_d.nascent_time_ms = pwdata[15:0];
        REG_DYING_TIME:   cfg_d.dying_time_ms   = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nascent_time_ms <= 16'd500;
      cfg_q.dying_time_ms   <= 16'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_NASCENT_TIME: prdata = {16'b0, cfg_q.nascent_time_ms};
      REG_DYING_TIME:   prdata = {16'b0, cfg_q.dying_time_ms};
      default:          prdata = '0;
    endcase
  end

  // sequencer: accept, execute, trail walk
  btl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // state, smoothing, trail ring and output register
  btl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/btl_ram.sv */
module btl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 20,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/btl_ctrl.sv */
`include "blob_track_lifecycle_defines.svh"

module btl_ctrl import btl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  ctrl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (st_i.read_nonempty) begin
          cmd_o.rd_start = 1'b1;
          state_d        = CS_RD_REQ;
        end else if (st_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      CS_RD_REQ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = CS_RD_EMIT;
      end
      CS_RD_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_point = 1'b1;
          state_d          = st_i.rd_last ? CS_IDLE : CS_RD_REQ;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  `BTL_ASSERT(a_accept_then_busy, (in_valid_i && !in_stall_o) |=> in_stall_o, "beat taken while busy")
  `BTL_ASSERT(a_emit_needs_slot, (cmd_o.exec || cmd_o.emit_point) |-> st_i.out_free, "output overrun")
  `BTL_ASSERT(a_walk_reads_first, cmd_o.rd_start |=> cmd_o.rd_req, "trail walk skipped read")

endmodule

/* hdl/btl_dp.sv */
`include "blob_track_lifecycle_defines.svh"

module btl_dp import btl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t st_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output out_t    out_data_o
);

  // latched event
  logic [2:0]  op_q;
  logic [31:0] time_q;
  logic [15:0] cx_q, cy_q;

  // track state
  life_e                 state_q, state_d;
  logic [31:0]           nstart_q, nstart_d;
  logic [31:0]           dstart_q, dstart_d;
  logic                  dflag_q, dflag_d;
  logic [15:0]           sx_q, sx_d, sy_q, sy_d;
  logic [TrailIdxW-1:0]  head_q, head_d;
  logic [TrailCntW-1:0]  fill_q, fill_d;

  // trail walk
  logic [TrailIdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [TrailCntW-1:0]  rd_left_q, rd_left_d;

  // output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic out_load;

  logic        ram_we;
  logic [31:0] ram_wdata, ram_rdata;

  logic [16:0]        sx_sum, sy_sum;
  logic [31:0]        n_elapsed, d_elapsed;
  logic [TrailIdxW:0] sidx_sum;
  logic [TrailIdxW:0] sidx;

  assign sx_sum    = {1'b0, sx_q} + {1'b0, cx_q};
  assign sy_sum    = {1'b0, sy_q} + {1'b0, cy_q};
  assign n_elapsed = time_q - nstart_q;
  assign d_elapsed = time_q - dstart_q;

  // oldest held point: head - fill, modulo depth
  assign sidx_sum = {1'b0, head_q} + (TrailIdxW+1)'(TrailDepth) - (TrailIdxW+1)'(fill_q);
  assign sidx     = (sidx_sum >= (TrailIdxW+1)'(TrailDepth))
                    ? sidx_sum - (TrailIdxW+1)'(TrailDepth) : sidx_sum;

  assign st_o.read_nonempty = (op_q == OP_READ) && (fill_q != '0);
  assign st_o.out_free      = !out_valid_q || !out_stall_i;
  assign st_o.rd_last       = (rd_left_q == TrailCntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      time_q <= in_data_i.time_ms;
      cx_q   <= box_center(in_data_i.rect_x, in_data_i.rect_w);
      cy_q   <= box_center(in_data_i.rect_y, in_data_i.rect_h);
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LS_DEAD;
      nstart_q    <= '0;
      dstart_q    <= '0;
      dflag_q     <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nstart_q    <= nstart_d;
      dstart_q    <= dstart_d;
      dflag_q     <= dflag_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // event update
  always_comb begin
    state_d   = state_q;
    nstart_d  = nstart_q;
    dstart_d  = dstart_q;
    dflag_d   = dflag_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    head_d    = head_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_wdata = {sy_sum[16:1], sx_sum[16:1]};
    if (cmd_i.exec) begin
      case (op_q)
        OP_START: begin
          nstart_d = time_q;
          sx_d     = cx_q;
          sy_d     = cy_q;
          dflag_d  = 1'b0;
          state_d  = LS_NASCENT;
          head_d   = '0;
          fill_d   = '0;
        end
        OP_SEEN: begin
          if (state_q inside {LS_BORN, LS_ALIVE}) begin
            state_d = LS_ALIVE;
            dflag_d = 1'b0;
            sx_d    = sx_sum[16:1];
            sy_d    = sy_sum[16:1];
            ram_we  = 1'b1;
            head_d  = (head_q == TrailIdxW'(TrailDepth - 1)) ? '0 : head_q + 1'b1;
            if (fill_q != TrailCntW'(TrailDepth)) begin
              fill_d = fill_q + 1'b1;
            end
          end else if (state_q == LS_NASCENT &&
                       n_elapsed > {16'b0, cfg_i.nascent_time_ms}) begin
            state_d = LS_BORN;
          end
        end
        OP_MISSED: begin
          if (state_q == LS_ALIVE) begin
            if (!dflag_q) begin
              dflag_d  = 1'b1;
              dstart_d = time_q;
            end else if (d_elapsed > {16'b0, cfg_i.dying_time_ms}) begin
              state_d = LS_DEAD;
            end
          end else begin
            state_d = LS_DEAD;
          end
        end
        OP_TERM: begin
          state_d = LS_DEAD;
          head_d  = '0;
          fill_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // trail walk and output register
  always_comb begin
    rd_idx_d    = rd_idx_q;
    rd_left_d   = rd_left_q;
    out_load    = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.rd_start) begin
      rd_idx_d  = TrailIdxW'(sidx);
      rd_left_d = fill_q;
    end
    if (cmd_i.exec) begin
      out_load          = 1'b1;
      out_d.life_state  = state_d;
      out_d.pos_x       = sx_d;
      out_d.pos_y       = sy_d;
      out_d.dying       = dflag_d && (state_d == LS_ALIVE);
      out_d.trail_count = 5'(fill_d);
      out_d.last        = 1'b1;
    end else if (cmd_i.emit_point) begin
      out_load          = 1'b1;
      out_d.life_state  = state_q;
      out_d.pos_x       = ram_rdata[15:0];
      out_d.pos_y       = ram_rdata[31:16];
      out_d.dying       = dflag_q && (state_q == LS_ALIVE);
      out_d.trail_count = 5'(fill_q);
      out_d.last        = st_o.rd_last;
      rd_idx_d  = (rd_idx_q == TrailIdxW'(TrailDepth - 1)) ? '0 : rd_idx_q + 1'b1;
      rd_left_d = rd_left_q - 1'b1;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  btl_ram #(
    .WIDTH (32),
    .DEPTH (TrailDepth)
  ) u_trail (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_req),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BTL_ASSERT(a_fill_bound, fill_q <= TrailCntW'(TrailDepth), "trail fill past depth")
  `BTL_NEVER(a_walk_underrun, cmd_i.emit_point && (rd_left_q == '0), "trail walk past end")
  `BTL_ASSERT(a_out_hold, (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)), "stalled beat changed")

endmodule

/* test/blob_track_lifecycle_tb.sv */
`timescale 1ns / 1ps

module blob_track_lifecycle_tb;
  import btl_pkg::*;

  // Longest walk is a full trail read of 20 points; the drain pad covers it.
  localparam int DrainCycles = 50;
  localparam int PhaseItems  = 34;
  localparam int MaxPrinted  = 60;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                ev_valid = 1'b0;
  logic                ev_stall;
  in_t                 ev_beat = '0;

  logic                res_valid;
  logic                res_stall = 1'b0;
  out_t                res_beat;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  blob_track_lifecycle DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_beat),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Event beats waiting to be driven, and status/trail beats the track owes us.
  in_t         event_backlog [$];
  out_t        due_beats [$];
  int unsigned queued_items = 0;
  int unsigned err_count = 0;

  // Per-cycle odds (percent) of the sender idling and the receiver stalling.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Shadow of the track: registers first, then lifecycle state and trail ring.
  logic [15:0] nas_lim = 16'd500;
  logic [15:0] dy_lim  = 16'd500;
  life_e       trk_life = LS_DEAD;
  logic [31:0] born_ref_ms = '0;
  logic [31:0] miss_ref_ms = '0;
  logic        dying_mark = 1'b0;
  logic [15:0] sm_x = '0;
  logic [15:0] sm_y = '0;
  logic [31:0] trail_mem [TrailDepth];
  int          trail_wr = 0;
  int          trail_cnt = 0;

  task automatic log_error(input string msg);
    if (err_count < MaxPrinted) $display("%0t ERROR %s", $realtime, msg);
    err_count++;
  endtask

  // 12.4 box center: left edge plus half the size, clamped at the top of range.
  function automatic logic [15:0] center_12q4(logic [11:0] lo_px, logic [11:0] span_px);
    int unsigned c;
    c = int'(lo_px) * 16 + int'(span_px) * 8;
    return (c > 32'd65535) ? 16'hFFFF : 16'(c);
  endfunction

  function automatic out_t make_beat(logic [15:0] px, logic [15:0] py, logic is_last);
    out_t b;
    b.life_state  = trk_life;
    b.pos_x       = px;
    b.pos_y       = py;
    b.dying       = dying_mark && (trk_life == LS_ALIVE);
    b.trail_count = 5'(trail_cnt);
    b.last        = is_last;
    return b;
  endfunction

  // Appends one owed beat at the tail of the expected queue.
  function automatic void owe_beat(out_t b);
    due_beats = {due_beats, b};
  endfunction

  // Applies one accepted event to the shadow and queues the beats it owes.
  function automatic void advance_track(in_t ev);
    logic [15:0] cx;
    logic [15:0] cy;
    logic [31:0] dt;
    int          n;
    int          slot;
    cx = center_12q4(ev.rect_x, ev.rect_w);
    cy = center_12q4(ev.rect_y, ev.rect_h);
    case (ev.opcode)
      OP_START: begin
        born_ref_ms = ev.time_ms;
        sm_x        = cx;
        sm_y        = cy;
        dying_mark  = 1'b0;
        trk_life    = LS_NASCENT;
        trail_wr    = 0;
        trail_cnt   = 0;
      end
      OP_SEEN: begin
        if (trk_life == LS_BORN) trk_life = LS_ALIVE;
        if (trk_life == LS_ALIVE) begin
          dying_mark = 1'b0;
          sm_x = 16'((17'(sm_x) + 17'(cx)) >> 1);
          sm_y = 16'((17'(sm_y) + 17'(cy)) >> 1);
          trail_mem[trail_wr] = {sm_y, sm_x};
          trail_wr = (trail_wr + 1) % int'(TrailDepth);
          if (trail_cnt < int'(TrailDepth)) trail_cnt++;
        end else if (trk_life == LS_NASCENT) begin
          dt = ev.time_ms - born_ref_ms;
          if (dt > {16'h0, nas_lim}) trk_life = LS_BORN;
        end
      end
      OP_MISSED: begin
        if (trk_life == LS_ALIVE) begin
          // first miss only marks; a mark at time zero is still a mark
          if (!dying_mark) begin
            dying_mark  = 1'b1;
            miss_ref_ms = ev.time_ms;
          end else begin
            dt = ev.time_ms - miss_ref_ms;
            if (dt > {16'h0, dy_lim}) trk_life = LS_DEAD;
          end
        end else begin
          trk_life = LS_DEAD;
        end
      end
      OP_TERM: begin
        trk_life  = LS_DEAD;
        trail_wr  = 0;
        trail_cnt = 0;
      end
      OP_READ: begin
        n = trail_cnt;
        if (n != 0) begin
          // oldest point first, last flag on the newest
          for (int i = 0; i < n; i++) begin
            slot = (trail_wr + int'(TrailDepth) - n + i) % int'(TrailDepth);
            owe_beat(make_beat(trail_mem[slot][15:0], trail_mem[slot][31:16],
                               i == n - 1));
          end
          return;
        end
      end
      default: ;
    endcase
    owe_beat(make_beat(sm_x, sm_y, 1'b1));
  endfunction

  task automatic cmp_field(input string fld, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_error($sformatf("%s: got %0d, want %0d", fld, got, want));
  endtask

  task automatic check_beat(input out_t got);
    out_t want;
    if (due_beats.size() == 0) begin
      log_error($sformatf("result beat %h with nothing pending", got));
      return;
    end
    want = due_beats.pop_front();
    cmp_field("life_state", 32'(got.life_state), 32'(want.life_state));
    cmp_field("pos_x", 32'(got.pos_x), 32'(want.pos_x));
    cmp_field("pos_y", 32'(got.pos_y), 32'(want.pos_y));
    cmp_field("dying", 32'(got.dying), 32'(want.dying));
    cmp_field("trail_count", 32'(got.trail_count), 32'(want.trail_count));
    cmp_field("last", 32'(got.last), 32'(want.last));
  endtask

  // Driver: holds a beat until taken, then pulls the next one from the backlog
  // unless this cycle rolls an idle. The shadow is advanced on each accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      ev_valid <= 1'b0;
    end else begin
      if (ev_valid && !ev_stall) advance_track(ev_beat);
      if (!ev_valid || !ev_stall) begin
        if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev_beat  <= event_backlog.pop_front();
          ev_valid <= 1'b1;
        end else begin
          ev_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result beat and rolls the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_valid && !res_stall) check_beat(res_beat);
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic post_box(input logic [2:0] op, input logic [31:0] t,
                          input logic [11:0] x, input logic [11:0] y,
                          input logic [11:0] w, input logic [11:0] h);
    in_t ev;
    ev.opcode  = op;
    ev.time_ms = t;
    ev.rect_x  = x;
    ev.rect_y  = y;
    ev.rect_w  = w;
    ev.rect_h  = h;
    event_backlog = {event_backlog, ev};
    queued_items++;
  endtask

  task automatic post_ev(input logic [2:0] op, input logic [31:0] t);
    post_box(op, t, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // Waits until the block has drained every owed beat, then pads for the tail.
  task automatic settle();
    while (event_backlog.size() != 0 || ev_valid || due_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register access: setup phase, then access phase until pready.
  // Writes update the shadow; reads are checked against it.
  task automatic cfg_access(input reg_idx_e idx, input logic wr, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr) begin
      if (idx == REG_NASCENT_TIME) nas_lim = val;
      else dy_lim = val;
    end else begin
      cmp_field("prdata", prdata, {16'h0, (idx == REG_NASCENT_TIME) ? nas_lim : dy_lim});
    end
  endtask

  task automatic set_limits(input logic [15:0] nas, input logic [15:0] dy);
    cfg_access(REG_NASCENT_TIME, 1'b1, nas);
    cfg_access(REG_DYING_TIME, 1'b1, dy);
    cfg_access(REG_NASCENT_TIME, 1'b0, '0);
    cfg_access(REG_DYING_TIME, 1'b0, '0);
  endtask

  // One mostly well-formed life: start, early sightings, birth, an alive run
  // that may wrap the trail, then one of several endings.
  task automatic queue_track_life();
    logic [31:0] t0;
    logic [31:0] tm;
    t0 = $urandom;
    post_ev(OP_START, t0);
    repeat ($urandom_range(2)) post_ev(OP_SEEN, t0 + $urandom_range(nas_lim));
    if ($urandom_range(3) == 0) post_ev(OP_READ, $urandom);
    post_ev(OP_SEEN, t0 + nas_lim + 32'd1 + (($urandom_range(1) != 0) ? 0 : $urandom_range(3000)));
    if ($urandom_range(7) == 0) begin
      // broken: miss while born
      post_ev(OP_MISSED, $urandom);
      return;
    end
    repeat ($urandom_range(26, 1)) begin
      case ($urandom_range(9))
        0: post_ev(OP_READ, $urandom);
        1: post_ev(OP_MISSED, $urandom);
        default: post_ev(OP_SEEN, $urandom);
      endcase
    end
    tm = $urandom;
    case ($urandom_range(3))
      0: begin
        // fresh mark, survive at the limit, die one past it
        post_ev(OP_SEEN, $urandom);
        post_ev(OP_MISSED, tm);
        post_ev(OP_MISSED, tm + dy_lim);
        post_ev(OP_MISSED, tm + dy_lim + 32'd1);
        post_ev(OP_READ, $urandom);
      end
      1: begin
        post_ev(OP_TERM, $urandom);
        post_ev(OP_READ, $urandom);
      end
      2: post_ev(OP_READ, $urandom);
      default: begin
        post_ev(OP_MISSED, tm);
        post_ev(OP_MISSED, tm + $urandom_range(dy_lim));
        post_ev(OP_SEEN, $urandom);
        post_ev(OP_READ, $urandom);
      end
    endcase
  endtask

  initial begin
    int unsigned send_pct_of [4];
    int unsigned recv_pct_of [4];
    logic [15:0] nas_of [6];
    logic [15:0] dy_of [6];
    int unsigned base;
    send_pct_of = '{0, 84, 0, 18};
    recv_pct_of = '{0, 0, 84, 18};
    nas_of = '{16'd0, 16'hFFFF, 16'($urandom_range(1000, 1)), 16'hFFFF, 16'd0,
               16'($urandom)};
    dy_of  = '{16'd0, 16'hFFFF, 16'($urandom_range(1000, 1)), 16'd0, 16'hFFFF,
               16'($urandom)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset values of both registers
    cfg_access(REG_NASCENT_TIME, 1'b0, '0);
    cfg_access(REG_DYING_TIME, 1'b0, '0);

    // Directed part, reset limits of 500 ms, no idling.
    post_ev(OP_READ, 32'd0);                     // empty trail while dead
    post_ev(OP_SEEN, 32'd0);                     // sighting of a dead track
    post_ev(OP_MISSED, 32'd0);
    post_ev(3'd5, 32'hFFFF_FFFF);                // unknown opcodes
    post_ev(3'd6, 32'h5555_5555);
    post_ev(3'd7, 32'hAAAA_AAAA);
    // start near wrap, box saturating both centers
    post_box(OP_START, 32'hFFFF_FF00, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    post_ev(OP_SEEN, 32'hFFFF_FF00 + 32'd500);   // exactly at the limit: still nascent
    post_ev(OP_SEEN, 32'hFFFF_FF00 + 32'd501);   // one past, across the wrap: born
    post_box(OP_SEEN, 32'd0, 12'h000, 12'h000, 12'h000, 12'h000);
    post_box(OP_SEEN, 32'd0, 12'hFFF, 12'h000, 12'h000, 12'hFFF);
    post_ev(OP_READ, 32'd0);
    post_ev(OP_MISSED, 32'd0);                   // dying mark at time zero
    post_ev(OP_SEEN, 32'd7);                     // sighting clears it
    post_ev(OP_MISSED, 32'd0);
    post_ev(OP_MISSED, 32'd500);                 // at the dying limit: survives
    post_ev(OP_MISSED, 32'd501);                 // past it: dead
    post_ev(OP_READ, 32'd0);                     // trail still held after death
    post_ev(OP_TERM, 32'd0);
    post_ev(OP_READ, 32'd0);
    post_box(OP_START, 32'd100, 12'h000, 12'h000, 12'hFFF, 12'hFFF);
    post_ev(OP_MISSED, 32'd100);                 // miss while nascent
    post_ev(OP_START, 32'd1000);
    post_ev(OP_SEEN, 32'd1501);
    post_ev(OP_MISSED, 32'd1502);                // miss while born
    settle();

    // Random phases, each with its own limits and one of four idling mixes. Every phase
    // pauses once mid-way until all owed beats are back.
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(nas_of[ph], dy_of[ph]);
      send_idle_pct  = send_pct_of[ph % 4];
      recv_stall_pct = recv_pct_of[ph % 4];
      base = queued_items;
      while (queued_items < base + PhaseItems / 2) begin
        if ($urandom_range(4) == 0) repeat ($urandom_range(4, 1)) post_ev(3'($urandom), $urandom);
        else queue_track_life();
      end
      settle();
      while (queued_items < base + PhaseItems) begin
        if ($urandom_range(4) == 0) repeat ($urandom_range(4, 1)) post_ev(3'($urandom), $urandom);
        else queue_track_life();
      end
      settle();
    end

    if (err_count == 0) begin
      $display("blob_track_lifecycle_tb: PASS");
    end else begin
      $display("blob_track_lifecycle_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("blob_track_lifecycle_tb: FAIL");
    $finish;
  end

endmodule
